>>> hdl/ilie_pkg.sv
// Package for the indexed list block: word layouts of both channels, command
// and status codes, cell control word and default sizes.
// No dependencies; every other file of the block refers to it by scoped names.
package ilie_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int CAPACITY_DEFAULT     = 256;
    localparam int ELEMENT_BITS_DEFAULT = 32;

    // Widest values the parameters may take, used for fixed-width internal words.
    localparam int MAX_ELEM_BITS = 64;
    localparam int MAX_POS_W     = 13;

    // Field widths of the channel words.
    localparam int CMD_BITS    = 3;
    localparam int POS_BITS    = 9;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 9;
    localparam int STATUS_BITS = 2;

    // Cells are collected into groups of this size for the read path.
    localparam int GROUP_CELLS = 16;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_SET    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_ERASE  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] element;
    } cmd_word_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0]  entry_count;
        logic [STATUS_BITS-1:0] status;
    } rsp_word_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic                     rd;
        logic [MAX_POS_W-1:0]     pos;
        logic [MAX_ELEM_BITS-1:0] data;
    } cell_ctl_t;

endpackage

>>> hdl/indexed_list_insert_erase.sv
// Indexed list with insert and erase: top level.
// Depends on ilie_pkg, ilie_cell and ilie_read_group.
//
// The block keeps an ordered list of up to CAPACITY element words in a row of
// cells, one word per cell, plus a count of the entries in use. Commands come
// in on the cmd channel (cmd_valid, cmd_stall, cmd) and each one produces
// exactly one word on the rsp channel (rsp_valid, rsp_stall, rsp) carrying
// the value read, the count after the command and a status.
//
// A command word is taken when cmd_valid is high and cmd_stall is low. The
// block handles one command at a time: it latches the command; in the
// execute state all cells shift or write in parallel and the read groups
// capture the selected word; in the gather state the groups are merged into
// the response register. A new command is taken only once the last one has
// left the gather state, and rsp_valid rises with the load of that register.
//
// The response register holds its word while rsp_stall is high; a finished
// command then waits in its merge cycle and cmd_stall stays high until the
// response can move. Reset clears the count, the control state and the
// response valid; cell contents are not cleared and cannot be read again
// until they are rewritten.
module indexed_list_insert_erase #(
    parameter int CAPACITY     = ilie_pkg::CAPACITY_DEFAULT,
    parameter int ELEMENT_BITS = ilie_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ilie_pkg::cmd_word_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ilie_pkg::rsp_word_t rsp
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int NGROUPS = (CAPACITY + ilie_pkg::GROUP_CELLS - 1) / ilie_pkg::GROUP_CELLS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_GATHER = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    ilie_pkg::cmd_word_t cmd_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [ilie_pkg::STATUS_BITS-1:0] status_reg;
    logic [ilie_pkg::STATUS_BITS-1:0] status_next;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    ilie_pkg::rsp_word_t rsp_reg;
    logic                rsp_load;

    ilie_pkg::cell_ctl_t cell_ctl;

    logic [ilie_pkg::MAX_POS_W-1:0] pos_ext;
    logic [ilie_pkg::MAX_POS_W-1:0] cnt_ext;
    logic                           list_full;

    logic [CAPACITY-1:0][ELEMENT_BITS-1:0] cell_words;
    logic [CAPACITY-1:0][ELEMENT_BITS-1:0] cell_rd;
    logic [NGROUPS-1:0][ELEMENT_BITS-1:0]  group_words;
    logic [ELEMENT_BITS-1:0]               gathered;
    logic [ilie_pkg::MAX_ELEM_BITS-1:0]    gathered_wide;

    // Accepted command word.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
    end

    assign pos_ext   = ilie_pkg::MAX_POS_W'(cmd_reg.position);
    assign cnt_ext   = ilie_pkg::MAX_POS_W'(count_reg);
    assign list_full = (count_reg == CNT_W'(CAPACITY));

    // Command decode. Range checks come before the full check for insert.
    // Cell actions are issued only in the execute cycle.
    always_comb
    begin
        cell_ctl.op   = ilie_pkg::CELL_HOLD;
        cell_ctl.rd   = 1'b0;
        cell_ctl.pos  = pos_ext;
        cell_ctl.data = ilie_pkg::MAX_ELEM_BITS'(cmd_reg.element);
        count_next    = count_reg;
        status_next   = status_reg;
        if (state_reg == S_EXEC)
        begin
            status_next = ilie_pkg::ST_OK;
            unique case (cmd_reg.command)
                ilie_pkg::CMD_APPEND:
                begin
                    if (list_full)
                    begin
                        status_next = ilie_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_ctl.op  = ilie_pkg::CELL_WRITE;
                        cell_ctl.pos = cnt_ext;
                        count_next   = count_reg + 1'b1;
                    end
                end
                ilie_pkg::CMD_INSERT:
                begin
                    if (pos_ext > cnt_ext)
                    begin
                        status_next = ilie_pkg::ST_RANGE;
                    end
                    else if (list_full)
                    begin
                        status_next = ilie_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_ctl.op = ilie_pkg::CELL_INSERT;
                        count_next  = count_reg + 1'b1;
                    end
                end
                ilie_pkg::CMD_SET:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ilie_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cell_ctl.op = ilie_pkg::CELL_WRITE;
                    end
                end
                ilie_pkg::CMD_GET:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ilie_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cell_ctl.rd = 1'b1;
                    end
                end
                ilie_pkg::CMD_ERASE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ilie_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cell_ctl.op = ilie_pkg::CELL_ERASE;
                        count_next  = count_reg - 1'b1;
                    end
                end
                ilie_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // Unused command codes change nothing and report ok.
                    status_next = ilie_pkg::ST_OK;
                end
            endcase
        end
    end

    // The row of cells. The end cells see themselves where a neighbor is missing;
    // cell 0 never takes that word, and the last cell keeps its own on an erase.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEMENT_BITS-1:0] lower_word;
        logic [ELEMENT_BITS-1:0] upper_word;

        if (i == 0)
        begin : g_first
            assign lower_word = cell_words[i];
        end
        else
        begin : g_inner_lo
            assign lower_word = cell_words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_word = cell_words[i];
        end
        else
        begin : g_inner_hi
            assign upper_word = cell_words[i+1];
        end

        ilie_cell #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .INDEX        (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .lower   (lower_word),
            .upper   (upper_word),
            .word    (cell_words[i]),
            .rd_word (cell_rd[i])
        );
    end

    // First read level: one registered collector per group of cells.
    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        localparam int BASE = g * ilie_pkg::GROUP_CELLS;
        localparam int N    = (CAPACITY - BASE < ilie_pkg::GROUP_CELLS) ?
                              (CAPACITY - BASE) : ilie_pkg::GROUP_CELLS;

        ilie_read_group #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .N            (N)
        ) u_group (
            .clk        (clk),
            .load       (state_reg == S_EXEC),
            .words      (cell_rd[BASE +: N]),
            .group_word (group_words[g])
        );
    end

    // Second read level: merge the group words in the gather cycle. Only a
    // successful get leaves a nonzero word, so every other command reads 0.
    always_comb
    begin
        gathered = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            gathered = gathered | group_words[g];
        end
    end

    assign gathered_wide = ilie_pkg::MAX_ELEM_BITS'(gathered);

    assign rsp_load = (state_reg == S_GATHER) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_GATHER;
            end
            S_GATHER:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ilie_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.read_value  <= gathered_wide[ilie_pkg::VALUE_BITS-1:0];
            rsp_reg.entry_count <= cnt_ext[ilie_pkg::COUNT_BITS-1:0];
            rsp_reg.status      <= status_reg;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted command always goes to the execute cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

    // A response appears only out of the gather cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_GATHER))
        else $error("response without a gather cycle");

    // A failed command never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != ilie_pkg::ST_OK)) |->
        (rsp_reg.read_value == '0))
        else $error("data returned with an error status");

    // A full status means the list is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ilie_pkg::ST_FULL)) |->
        (rsp_reg.entry_count == ilie_pkg::COUNT_BITS'(CAPACITY)))
        else $error("full status below capacity");
`endif

endmodule

>>> hdl/ilie_cell.sv
// One storage cell of the list: holds one element word and trades it with its
// neighbors on insert and erase. Depends on ilie_pkg.
module ilie_cell #(
    parameter int ELEMENT_BITS = ilie_pkg::ELEMENT_BITS_DEFAULT,
    parameter int INDEX        = 0
) (
    input  logic                     clk,
    input  ilie_pkg::cell_ctl_t      ctl,
    input  logic [ELEMENT_BITS-1:0]  lower,
    input  logic [ELEMENT_BITS-1:0]  upper,
    output logic [ELEMENT_BITS-1:0]  word,
    output logic [ELEMENT_BITS-1:0]  rd_word
);

    localparam logic [ilie_pkg::MAX_POS_W-1:0] IDX = ilie_pkg::MAX_POS_W'(INDEX);

    logic [ELEMENT_BITS-1:0] word_reg;
    logic [ELEMENT_BITS-1:0] word_next;
    logic                    hit;

    assign hit = (ctl.pos == IDX);

    always_comb
    begin
        word_next = word_reg;
        unique case (ctl.op)
            ilie_pkg::CELL_WRITE:
            begin
                if (hit)
                begin
                    word_next = ctl.data[ELEMENT_BITS-1:0];
                end
            end
            ilie_pkg::CELL_INSERT:
            begin
                // Entries above the insert point move up by one.
                if (hit)
                begin
                    word_next = ctl.data[ELEMENT_BITS-1:0];
                end
                else if (IDX > ctl.pos)
                begin
                    word_next = lower;
                end
            end
            ilie_pkg::CELL_ERASE:
            begin
                // Entries from the erase point on take their upper neighbor.
                if (IDX >= ctl.pos)
                begin
                    word_next = upper;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (ctl.rd && hit) ? word_reg : '0;

endmodule

>>> hdl/ilie_read_group.sv
// Read collector for one group of cells: ORs the selected cell words of the
// group and registers the result. Depends on ilie_pkg only for defaults.
module ilie_read_group #(
    parameter int ELEMENT_BITS = ilie_pkg::ELEMENT_BITS_DEFAULT,
    parameter int N            = ilie_pkg::GROUP_CELLS
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic [N-1:0][ELEMENT_BITS-1:0]  words,
    output logic [ELEMENT_BITS-1:0]         group_word
);

    logic [ELEMENT_BITS-1:0] group_reg;
    logic [ELEMENT_BITS-1:0] group_next;

    // At most one cell of the whole list drives a nonzero word.
    always_comb
    begin
        group_next = '0;
        for (int k = 0; k < N; k++)
        begin
            group_next = group_next | words[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group_next;
        end
    end

    assign group_word = group_reg;

endmodule

>>> verif/indexed_list_insert_erase_test.sv
// Self-checking test of indexed_list_insert_erase. A shadow copy of the list
// predicts every response word, and each response is checked field by field.
// Depends on ilie_pkg and the indexed_list_insert_erase RTL; reads no files.
module indexed_list_insert_erase_test;

    localparam int LIST_DEPTH  = ilie_pkg::CAPACITY_DEFAULT;
    localparam int POS_LIMIT   = 1 << ilie_pkg::POS_BITS;
    localparam int QUIET_LIMIT = 400;
    localparam int MAX_REPORTS = 10;

    // The two command codes the block leaves unused; it must answer them
    // with an unchanged count, status ok and a zero value.
    localparam logic [ilie_pkg::CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [ilie_pkg::CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    ilie_pkg::cmd_word_t cmd;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    ilie_pkg::rsp_word_t rsp;

    // Shadow of the list contents and its length, updated at the edge where
    // a command word is taken by the block.
    logic [ilie_pkg::VALUE_BITS-1:0] shadow_words [LIST_DEPTH];
    int unsigned                     shadow_len = 0;

    // Response words predicted but not yet seen, oldest first.
    ilie_pkg::rsp_word_t awaited_rsp [$];

    int mismatch_count    = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stall_left        = 0;

    indexed_list_insert_erase uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one accepted command to the shadow list and queues the
    // response word it must produce. Insert accepts any index up to and
    // including the current length, and its index check wins over the
    // full check. Clear only drops the length; the old words stay behind
    // but can never be read before they are written again.
    function automatic void shadow_list_apply(input ilie_pkg::cmd_word_t c);
        ilie_pkg::rsp_word_t r;
        int unsigned         pos;
        int unsigned         i;
        r   = '0;
        pos = c.position;
        case (c.command)
            ilie_pkg::CMD_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.status = ilie_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = c.element;
                    shadow_len++;
                end
            end
            ilie_pkg::CMD_INSERT:
            begin
                if (pos > shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else if (shadow_len >= LIST_DEPTH)
                    r.status = ilie_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = c.element;
                    shadow_len++;
                end
            end
            ilie_pkg::CMD_SET:
            begin
                if (pos >= shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else
                    shadow_words[pos] = c.element;
            end
            ilie_pkg::CMD_GET:
            begin
                if (pos >= shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else
                    r.read_value = shadow_words[pos];
            end
            ilie_pkg::CMD_ERASE:
            begin
                if (pos >= shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            end
            ilie_pkg::CMD_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.entry_count = shadow_len[ilie_pkg::COUNT_BITS-1:0];
        awaited_rsp.push_back(r);
    endfunction

    function automatic void report_mismatch(input string what,
                                            input ilie_pkg::rsp_word_t want,
                                            input ilie_pkg::rsp_word_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected value %h count %0d status %0d,",
                      " got value %h count %0d status %0d"},
                     $time, what, want.read_value, want.entry_count, want.status,
                     got.read_value, got.entry_count, got.status);
    endfunction

    function automatic void check_response(input ilie_pkg::rsp_word_t got);
        ilie_pkg::rsp_word_t want;
        if (awaited_rsp.size() == 0)
            report_mismatch("response word with none outstanding", '0, got);
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.read_value !== want.read_value || got.entry_count !== want.entry_count
                || got.status !== want.status)
                report_mismatch("response word differs", want, got);
        end
    endfunction

    // Response side. Signals are read right after the edge, before any
    // register in the block or here has taken its new value, so what is
    // seen is what the edge acted on. The stall comes in random bursts,
    // and never two bursts without a free cycle between.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rsp_stall <= 1'b0;
            end
            else if (receiver_idle_pct != 0 && $urandom_range(99) < receiver_idle_pct)
            begin
                stall_left = $urandom_range(19, 1);
                rsp_stall <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves a word for too long. The slowest
    // correct stretch is a sender gap plus a receiver burst plus the execute
    // and gather steps of one command, far below the limit.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("indexed_list_insert_erase regression: fail");
        $finish;
    end

    // Sends one command word and returns at the edge where it is taken.
    // Valid stays high on return so that back-to-back words never drop it;
    // a random sender gap lowers it instead.
    task automatic send_command(input logic [ilie_pkg::CMD_BITS-1:0] op,
                                input int unsigned pos,
                                input logic [ilie_pkg::VALUE_BITS-1:0] elem);
        ilie_pkg::cmd_word_t w;
        w.command  = op;
        w.position = pos[ilie_pkg::POS_BITS-1:0];
        w.element  = elem;
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        shadow_list_apply(w);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted response has arrived. At
    // least one edge passes, so valid is never lowered and raised in one step.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rsp.size() != 0);
    endtask

    // Mostly an index inside the given span, sometimes one beyond it, up to
    // the largest value the position field can carry.
    function automatic int unsigned pick_position(input int unsigned span);
        if (span != 0 && $urandom_range(99) < 88)
            return $urandom_range(span - 1, 0);
        return $urandom_range(POS_LIMIT - 1, span);
    endfunction

    // Random command mix. add_pct and erase_pct steer the list length up or
    // down; spare codes are thrown in but do not count toward n.
    task automatic run_random_commands(input int n, input int add_pct, input int erase_pct);
        int done;
        int roll;
        done = 0;
        while (done < n)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                send_command(roll == 0 ? CMD_SPARE_6 : CMD_SPARE_7,
                             $urandom_range(POS_LIMIT - 1), $urandom());
            else
            begin
                done++;
                if (roll < 3)
                    send_command(ilie_pkg::CMD_CLEAR, $urandom_range(POS_LIMIT - 1),
                                 $urandom());
                else if (roll < 3 + add_pct)
                begin
                    if ($urandom_range(1))
                        send_command(ilie_pkg::CMD_APPEND, $urandom_range(POS_LIMIT - 1),
                                     $urandom());
                    else
                        send_command(ilie_pkg::CMD_INSERT, pick_position(shadow_len + 1),
                                     $urandom());
                end
                else if (roll < 3 + add_pct + erase_pct)
                    send_command(ilie_pkg::CMD_ERASE, pick_position(shadow_len), $urandom());
                else if ($urandom_range(1))
                    send_command(ilie_pkg::CMD_SET, pick_position(shadow_len), $urandom());
                else
                    send_command(ilie_pkg::CMD_GET, pick_position(shadow_len), $urandom());
            end
        end
    endtask

    // Every command on an empty and on a short list, including the insert
    // bound at the current length, indexes just past the end and at the top
    // of the position field, both unused codes, and reads after a clear.
    task automatic test_empty_and_short_list();
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        send_command(ilie_pkg::CMD_GET, 0, 32'h0);
        send_command(ilie_pkg::CMD_ERASE, 0, 32'h0);
        send_command(ilie_pkg::CMD_SET, 0, 32'hFFFF_FFFF);
        send_command(ilie_pkg::CMD_INSERT, 1, 32'h1234_5678);
        send_command(ilie_pkg::CMD_APPEND, POS_LIMIT - 1, 32'hFFFF_FFFF);
        send_command(ilie_pkg::CMD_INSERT, 0, 32'h0000_0000);
        send_command(ilie_pkg::CMD_INSERT, 2, 32'h5A5A_5A5A);
        send_command(ilie_pkg::CMD_INSERT, 1, 32'hA5A5_A5A5);
        send_command(ilie_pkg::CMD_GET, 0, 32'h0);
        send_command(ilie_pkg::CMD_GET, 3, 32'h0);
        send_command(ilie_pkg::CMD_GET, 4, 32'h0);
        send_command(ilie_pkg::CMD_GET, POS_LIMIT - 1, 32'hFFFF_FFFF);
        send_command(ilie_pkg::CMD_SET, 3, $urandom());
        send_command(ilie_pkg::CMD_SET, 4, $urandom());
        send_command(ilie_pkg::CMD_ERASE, 1, 32'h0);
        send_command(ilie_pkg::CMD_GET, 1, 32'h0);
        send_command(ilie_pkg::CMD_ERASE, 2, 32'h0);
        send_command(ilie_pkg::CMD_ERASE, LIST_DEPTH, 32'h0);
        send_command(CMD_SPARE_6, POS_LIMIT - 1, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_7, $urandom_range(POS_LIMIT - 1), $urandom());
        send_command(ilie_pkg::CMD_CLEAR, 0, 32'h0);
        send_command(ilie_pkg::CMD_GET, 0, 32'h0);
        send_command(ilie_pkg::CMD_APPEND, 0, $urandom());
        send_command(ilie_pkg::CMD_GET, 0, 32'h0);
    endtask

    // Fills the list to capacity with random words, then works at the full
    // boundary: append and insert refused as full, an insert past the end
    // refused on its index first, and shifts across all the cells.
    task automatic test_full_list();
        int k;
        sender_idle_pct   = 5;
        receiver_idle_pct = 5;
        while (shadow_len < LIST_DEPTH)
        begin
            if ($urandom_range(3) == 0)
                send_command(ilie_pkg::CMD_INSERT, $urandom_range(shadow_len, 0), $urandom());
            else
                send_command(ilie_pkg::CMD_APPEND, $urandom_range(POS_LIMIT - 1), $urandom());
        end
        send_command(ilie_pkg::CMD_APPEND, 0, $urandom());
        send_command(ilie_pkg::CMD_INSERT, LIST_DEPTH, $urandom());
        send_command(ilie_pkg::CMD_INSERT, LIST_DEPTH + 1, $urandom());
        send_command(ilie_pkg::CMD_INSERT, 0, $urandom());
        send_command(ilie_pkg::CMD_GET, LIST_DEPTH - 1, 32'h0);
        send_command(ilie_pkg::CMD_GET, LIST_DEPTH, 32'h0);
        send_command(ilie_pkg::CMD_SET, LIST_DEPTH - 1, 32'hFFFF_FFFF);
        send_command(ilie_pkg::CMD_GET, LIST_DEPTH - 1, 32'h0);
        send_command(ilie_pkg::CMD_ERASE, LIST_DEPTH - 1, 32'h0);
        send_command(ilie_pkg::CMD_INSERT, 0, 32'h0);
        send_command(ilie_pkg::CMD_ERASE, 0, 32'h0);
        send_command(ilie_pkg::CMD_APPEND, 0, $urandom());
        for (k = 0; k < 16; k++)
        begin
            send_command(ilie_pkg::CMD_ERASE, $urandom_range(LIST_DEPTH - 1), $urandom());
            send_command(ilie_pkg::CMD_INSERT, $urandom_range(shadow_len), $urandom());
            send_command(ilie_pkg::CMD_GET, $urandom_range(LIST_DEPTH - 1), 32'h0);
        end
        send_command(ilie_pkg::CMD_CLEAR, 0, 32'h0);
    endtask

    // Random traffic in segments that push the length up, pull it down and
    // hold it, each with its own idling on the two channels; one segment has
    // no idling at all.
    task automatic test_random_traffic();
        sender_idle_pct   = 12;
        receiver_idle_pct = 12;
        run_random_commands(150, 50, 15);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_commands(100, 25, 40);
        sender_idle_pct   = 20;
        run_random_commands(100, 40, 30);
        sender_idle_pct   = 0;
        receiver_idle_pct = 25;
        run_random_commands(100, 40, 30);
    endtask

    // The sender stops until the block has answered everything, then
    // restarts with a back-to-back run of words.
    task automatic test_drain_then_burst();
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        run_random_commands(20, 45, 25);
        wait_for_drain();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_commands(30, 45, 25);
    endtask

    // Closing stretch at full rate on both channels.
    task automatic test_quiet_tail();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_commands(60, 40, 30);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_short_list();
        test_full_list();
        test_random_traffic();
        test_drain_then_burst();
        test_quiet_tail();

        // Let the last responses out and give a stray extra word time to show.
        wait_for_drain();
        repeat (12) @(posedge clk);
        if (awaited_rsp.size() != 0)
            $display("%0d response words never arrived", awaited_rsp.size());
        if (mismatch_count == 0 && awaited_rsp.size() == 0)
            $display("indexed_list_insert_erase regression: pass");
        else
            $display("indexed_list_insert_erase regression: fail");
        $finish;
    end

endmodule
